### hw/rtl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg: shared types and constants of the palette RLE row decoder
// Register codes, field widths and the control/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SIDE_W     = 7;
  localparam int unsigned OFF_W      = 6;
  localparam int unsigned RUN_W      = 5;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  // top three bits all set mark a run code
  localparam logic [2:0]        RUN_MARK          = 3'b111;
  localparam logic [BYTE_W-1:0] FIRST_CLEAR_INDEX = 8'd254;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPRESSED_MODE = 3'd0,
    CFG_IMAGE_WIDTH     = 3'd1,
    CFG_IMAGE_HEIGHT    = 3'd2,
    CFG_BUFFER_WIDTH    = 3'd3,
    CFG_X_OFFSET        = 3'd4,
    CFG_Y_OFFSET        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic accept;  // latch input beat, apply row/image start
    logic prep;    // classify byte, set pixel count, row base
    logic emit;    // write one pixel into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_pixels;  // prep found at least one pixel to write
    logic slot_free;   // output register can take a pixel this cycle
    logic last_pixel;  // pixel being emitted is the last of the burst
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/prd_in_if.sv
// ----------------------------------------------------------------------------
// prd_in_if: encoded byte channel
// Valid/ready channel carrying one stream byte and its row/image markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface prd_in_if;
  logic                          valid;
  logic                          ready;
  logic [prd_pkg::BYTE_W-1:0]    data_byte;
  logic                          row_start;
  logic                          image_start;

  modport source (output valid, data_byte, row_start, image_start, input ready);
  modport sink   (input valid, data_byte, row_start, image_start, output ready);
endinterface

`default_nettype wire

### hw/rtl/prd_out_if.sv
// ----------------------------------------------------------------------------
// prd_out_if: pixel write channel
// Valid/ready channel carrying one decoded pixel write per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface prd_out_if;
  logic                          valid;
  logic                          ready;
  logic [prd_pkg::ADDR_W-1:0]    pixel_address;
  logic [prd_pkg::BYTE_W-1:0]    palette_index;
  logic                          pixel_transparent;
  logic                          image_has_transparency;
  logic                          last_of_burst;
  logic                          image_done;

  modport source (output valid, pixel_address, palette_index, pixel_transparent,
                  image_has_transparency, last_of_burst, image_done, input ready);
  modport sink   (input valid, pixel_address, palette_index, pixel_transparent,
                  image_has_transparency, last_of_burst, image_done, output ready);
endinterface

`default_nettype wire

### hw/rtl/prd_ctrl.sv
// ----------------------------------------------------------------------------
// prd_ctrl: decoder sequencer
// Steps each input beat through accept, prep and pixel emission.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire prd_pkg::dp_status_t status,
  output prd_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_comb begin
    cmd.accept = in_ready_r && in_valid;
    cmd.prep   = (state_r == S_PREP);
    cmd.emit   = (state_r == S_EMIT) && status.slot_free;
  end

  assign in_ready = in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_PREP;
            in_ready_r <= 1'b0;
          end
        end
        S_PREP: begin
          if (status.has_pixels) begin
            state_r <= S_EMIT;
          end else begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_EMIT: begin
          if (status.slot_free && status.last_pixel) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_PREP)
    else $error("accepted beat did not move to prep");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.last_pixel) |=> (state_r == S_IDLE && in_ready_r))
    else $error("sequencer did not return to idle after last pixel");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE)
    else $error("ready raised outside idle");

endmodule

`default_nettype wire

### hw/rtl/prd_datapath.sv
// ----------------------------------------------------------------------------
// prd_datapath: decoder registers and pixel arithmetic
// Holds configuration, row/column state, run state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_datapath #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [prd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [prd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [prd_pkg::BYTE_W-1:0]        in_data_byte,
  input  wire logic                              in_row_start,
  input  wire logic                              in_image_start,
  input  wire prd_pkg::ctrl_cmd_t                cmd,
  output prd_pkg::dp_status_t                    status,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [prd_pkg::ADDR_W-1:0]             out_pixel_address,
  output logic [prd_pkg::BYTE_W-1:0]             out_palette_index,
  output logic                                   out_pixel_transparent,
  output logic                                   out_image_has_transparency,
  output logic                                   out_last_of_burst,
  output logic                                   out_image_done
);

  localparam int unsigned SW = prd_pkg::SIDE_W;
  localparam int unsigned RW = prd_pkg::RUN_W;
  localparam int unsigned AW = prd_pkg::ADDR_W;
  localparam int unsigned BW = prd_pkg::BYTE_W;
  localparam int unsigned OW = prd_pkg::OFF_W;
  localparam int unsigned SideCap = (MAX_SIDE > 127) ? 127 : MAX_SIDE;

  // configuration
  logic          comp_mode_r;
  logic [SW-1:0] img_w_r, img_h_r, buf_w_r;
  logic [OW-1:0] x_off_r, y_off_r;

  // decode state
  logic [SW-1:0] column_r, rows_left_r;
  logic          run_pending_r;
  logic [RW-1:0] pend_len_r;
  logic          row_done_r;
  logic          any_tr_r;
  logic [BW-1:0] byte_r;
  logic [AW-1:0] base_r;
  logic [RW-1:0] count_r;

  // output register
  logic          out_valid_r;
  logic [AW-1:0] addr_r;
  logic [BW-1:0] idx_r;
  logic          tr_r, has_tr_r, last_r, done_r;

  logic [SW-1:0] eff_w, eff_h;

  always_comb begin
    eff_w = (img_w_r > SW'(SideCap)) ? SW'(SideCap) : img_w_r;
    eff_h = (img_h_r > SW'(SideCap)) ? SW'(SideCap) : img_h_r;
  end

  // accept: image start / row start bookkeeping
  logic          rs;
  logic [SW-1:0] rows_acc, col_acc;
  logic          any_acc, done_acc, pend_acc;
  logic [RW-1:0] plen_acc;

  always_comb begin
    rows_acc = rows_left_r;
    col_acc  = column_r;
    any_acc  = any_tr_r;
    done_acc = row_done_r;
    pend_acc = run_pending_r;
    plen_acc = pend_len_r;
    rs       = in_row_start;
    if (in_image_start) begin
      rows_acc = eff_h;
      any_acc  = 1'b0;
      done_acc = 1'b1;
      col_acc  = '0;
      rs       = 1'b1;
    end
    if (rs) begin
      pend_acc = 1'b0;
      plen_acc = '0;
      if (rows_acc != '0) begin
        rows_acc = rows_acc - 1'b1;
        col_acc  = '0;
        done_acc = 1'b0;
      end else begin
        done_acc = 1'b1;
      end
    end
  end

  // prep: classify the latched byte
  logic [SW-1:0] room;
  logic [RW-1:0] pend_clamp, code_clamp, prep_count, prep_plen;
  logic          prep_pend, prep_done;
  logic [SW:0]   row_sum;
  logic [2*SW:0] row_prod;

  always_comb begin
    room       = eff_w - column_r;
    pend_clamp = ({2'b00, pend_len_r} > room) ? room[RW-1:0] : pend_len_r;
    code_clamp = ({2'b00, byte_r[RW-1:0]} > room) ? room[RW-1:0] : byte_r[RW-1:0];
    prep_count = '0;
    prep_pend  = run_pending_r;
    prep_plen  = pend_len_r;
    prep_done  = row_done_r;
    if (!row_done_r) begin
      if (column_r >= eff_w) begin
        prep_done = 1'b1;
      end else if (run_pending_r) begin
        prep_count = pend_clamp;
        prep_pend  = 1'b0;
        prep_plen  = '0;
      end else if (comp_mode_r && byte_r[BW-1 -: 3] == prd_pkg::RUN_MARK) begin
        prep_pend = 1'b1;
        prep_plen = code_clamp;
      end else begin
        prep_count = RW'(1);
      end
    end
    row_sum  = {1'b0, rows_left_r} + (SW+1)'(y_off_r);
    row_prod = row_sum * buf_w_r;
  end

  // emit: one pixel
  logic [SW-1:0] col_inc;
  logic          pix_tr, emit_row_done, emit_any;

  always_comb begin
    col_inc       = column_r + 1'b1;
    pix_tr        = (byte_r >= prd_pkg::FIRST_CLEAR_INDEX);
    emit_row_done = row_done_r || (col_inc >= eff_w);
    emit_any      = any_tr_r || pix_tr;
  end

  always_comb begin
    status.has_pixels = (prep_count != '0);
    status.slot_free  = !out_valid_r || out_ready;
    status.last_pixel = (count_r == RW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_mode_r   <= 1'b1;
      img_w_r       <= prd_pkg::SIDE_RESET;
      img_h_r       <= prd_pkg::SIDE_RESET;
      buf_w_r       <= prd_pkg::SIDE_RESET;
      x_off_r       <= '0;
      y_off_r       <= '0;
      column_r      <= '0;
      rows_left_r   <= '0;
      run_pending_r <= 1'b0;
      pend_len_r    <= '0;
      row_done_r    <= 1'b1;
      any_tr_r      <= 1'b0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          prd_pkg::CFG_COMPRESSED_MODE: comp_mode_r <= cfg_data[0];
          prd_pkg::CFG_IMAGE_WIDTH:     img_w_r     <= cfg_data;
          prd_pkg::CFG_IMAGE_HEIGHT:    img_h_r     <= cfg_data;
          prd_pkg::CFG_BUFFER_WIDTH:    buf_w_r     <= cfg_data;
          prd_pkg::CFG_X_OFFSET:        x_off_r     <= cfg_data[OW-1:0];
          prd_pkg::CFG_Y_OFFSET:        y_off_r     <= cfg_data[OW-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        rows_left_r   <= rows_acc;
        column_r      <= col_acc;
        any_tr_r      <= any_acc;
        row_done_r    <= done_acc;
        run_pending_r <= pend_acc;
        pend_len_r    <= plen_acc;
      end
      if (cmd.prep) begin
        run_pending_r <= prep_pend;
        pend_len_r    <= prep_plen;
        row_done_r    <= prep_done;
        count_r       <= prep_count;
      end
      if (cmd.emit) begin
        column_r   <= col_inc;
        row_done_r <= emit_row_done;
        any_tr_r   <= emit_any;
        count_r    <= count_r - 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_data_byte;
    end
    if (cmd.prep) begin
      base_r <= row_prod[AW-1:0];
    end
    if (cmd.emit) begin
      addr_r   <= base_r + AW'(x_off_r) + AW'(column_r);
      idx_r    <= byte_r;
      tr_r     <= pix_tr;
      has_tr_r <= emit_any;
      last_r   <= (count_r == RW'(1));
      done_r   <= emit_row_done && (rows_left_r == '0);
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_pixel_address          = addr_r;
  assign out_palette_index          = idx_r;
  assign out_pixel_transparent      = tr_r;
  assign out_image_has_transparency = has_tr_r;
  assign out_last_of_burst          = last_r;
  assign out_image_done             = done_r;

  a_emit_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> count_r != '0)
    else $error("pixel emitted with empty burst count");

  a_emit_open_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !row_done_r)
    else $error("pixel emitted into a completed row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(addr_r) && $stable(idx_r)))
    else $error("pixel beat changed while stalled");

endmodule

`default_nettype wire

### hw/rtl/palette_rle_row_decoder_unit.sv
// ----------------------------------------------------------------------------
// palette_rle_row_decoder_unit: palettized RLE bitmap to pixel writes
// Top level: sequencer plus datapath, byte channel in, pixel channel out.
// ----------------------------------------------------------------------------
// Takes one encoded byte per beat and turns it into pixel writes. A byte that
// writes nothing (run code, dropped byte, zero-length run) is only latched and
// classified; a byte that writes n pixels then emits them, one pixel per cycle
// out of the output register while the sink keeps up. The steps are set by the
// sequencer: latch the beat and apply row/image start, classify the byte and
// form the row base address with a single small multiply, then emit each
// pixel; no new byte is taken meanwhile. Rows fill bottom-up; image_start
// reloads the row count and clears the sticky transparency flag. Configuration
// writes are taken any time but must only be issued while no beat is in flight.
`default_nettype none

module palette_rle_row_decoder_unit #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prd_pkg::CFG_DATA_W-1:0] cfg_data,
  prd_in_if.sink                              in_ch,
  prd_out_if.source                           out_ch
);

  prd_pkg::ctrl_cmd_t  cmd;
  prd_pkg::dp_status_t status;

  prd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  prd_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg_wr_en                  (cfg_wr_en),
    .cfg_index                  (cfg_index),
    .cfg_data                   (cfg_data),
    .in_data_byte               (in_ch.data_byte),
    .in_row_start               (in_ch.row_start),
    .in_image_start             (in_ch.image_start),
    .cmd                        (cmd),
    .status                     (status),
    .out_valid                  (out_ch.valid),
    .out_ready                  (out_ch.ready),
    .out_pixel_address          (out_ch.pixel_address),
    .out_palette_index          (out_ch.palette_index),
    .out_pixel_transparent      (out_ch.pixel_transparent),
    .out_image_has_transparency (out_ch.image_has_transparency),
    .out_last_of_burst          (out_ch.last_of_burst),
    .out_image_done             (out_ch.image_done)
  );

endmodule

`default_nettype wire

### tb/tb_palette_rle_row_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_palette_rle_row_decoder_unit: self-checking bench for the RLE row decoder
// Streams encoded bytes into the unit and predicts every pixel write it
// should produce: addresses, palette indices and the transparency, burst-end
// and end-of-image flags. A directed part covers run codes, zero-length runs,
// dropped bytes, mode and width changes and address wrap. Random images
// follow under several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_palette_rle_row_decoder_unit;

  localparam int MAX_SIDE      = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_BEATS   = 40;
  localparam int NUM_PHASES    = 8;
  // register index with no register behind it
  localparam logic [prd_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd6;

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [prd_pkg::BYTE_W-1:0] data_byte;
    logic                       row_start;
    logic                       image_start;
  } byte_beat_t;

  typedef struct packed {
    logic [prd_pkg::ADDR_W-1:0] address;
    logic [prd_pkg::BYTE_W-1:0] pal_index;
    logic                       transparent;
    logic                       has_transparency;
    logic                       last_in_burst;
    logic                       done;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic                           cfg_wr_en;
  logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [prd_pkg::CFG_DATA_W-1:0] cfg_data;

  prd_in_if  in_ch ();
  prd_out_if out_ch ();

  palette_rle_row_decoder_unit #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // register copies
  logic       mode_r;
  logic [6:0] width_r, height_r, pitch_r;
  logic [5:0] xoff_r, yoff_r;

  // decoder state copy
  logic [6:0] cur_col, rows_to_go;
  logic       run_armed, row_closed, saw_clear;
  logic [4:0] run_len;

  byte_beat_t byte_q[$];
  pixel_t     pixel_q[$];
  int         beats_queued;
  int         mismatch_count;
  int         pixels_seen;
  idle_mode_t idle_mode;
  int         hold_token;

  function automatic logic [6:0] clamp_side(logic [6:0] v);
    return (v < MAX_SIDE) ? v : 7'(MAX_SIDE);
  endfunction

  task automatic put_pixel(logic [7:0] idx, bit last, logic [6:0] w);
    pixel_t p;
    int     addr;
    addr = (int'(rows_to_go) + int'(yoff_r)) * int'(pitch_r) + int'(xoff_r) + int'(cur_col);
    p.address     = addr[prd_pkg::ADDR_W-1:0];
    p.pal_index   = idx;
    p.transparent = (idx >= prd_pkg::FIRST_CLEAR_INDEX);
    if (p.transparent) saw_clear = 1'b1;
    cur_col = cur_col + 7'd1;
    if (cur_col >= w) row_closed = 1'b1;
    p.has_transparency = saw_clear;
    p.last_in_burst    = last;
    p.done             = row_closed && (rows_to_go == 7'd0);
    pixel_q.push_back(p);
  endtask

  // pixel writes caused by one accepted byte
  task automatic decode_byte(byte_beat_t b);
    logic [6:0] w;
    bit         rs;
    int         len, room;
    w  = clamp_side(width_r);
    rs = b.row_start;
    if (b.image_start) begin
      rows_to_go = clamp_side(height_r);
      saw_clear  = 1'b0;
      row_closed = 1'b1;
      cur_col    = '0;
      rs         = 1'b1;
    end
    if (rs) begin
      run_armed = 1'b0;
      run_len   = '0;
      if (rows_to_go > 0) begin
        rows_to_go = rows_to_go - 7'd1;
        cur_col    = '0;
        row_closed = 1'b0;
      end else begin
        row_closed = 1'b1;
      end
    end
    if (row_closed) return;
    if (cur_col >= w) begin
      row_closed = 1'b1;
      return;
    end
    room = int'(w) - int'(cur_col);
    if (run_armed) begin
      len = (int'(run_len) > room) ? room : int'(run_len);
      run_armed = 1'b0;
      run_len   = '0;
      for (int i = 0; i < len; i++) put_pixel(b.data_byte, i + 1 == len, w);
    end else if (mode_r && b.data_byte[7:5] == prd_pkg::RUN_MARK) begin
      len = (int'(b.data_byte[4:0]) > room) ? room : int'(b.data_byte[4:0]);
      run_len   = len[4:0];
      run_armed = 1'b1;
    end else begin
      put_pixel(b.data_byte, 1'b1, w);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t pixel %0d: %s", $time, pixels_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // driver: holds valid until the beat is taken
  always @(posedge clk) begin
    bit offering;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.data_byte   <= '0;
      in_ch.row_start   <= 1'b0;
      in_ch.image_start <= 1'b0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(byte_q.pop_front());
        offering = 1'b0;
      end
      if (!offering) begin
        if (byte_q.size() > 0 &&
            !(idle_mode == IDLE_SRC && $urandom_range(99) < 74) &&
            !(idle_mode == IDLE_BOTH && $urandom_range(99) < 14)) begin
          in_ch.valid       <= 1'b1;
          in_ch.data_byte   <= byte_q[0].data_byte;
          in_ch.row_start   <= byte_q[0].row_start;
          in_ch.image_start <= byte_q[0].image_start;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each pixel beat with the oldest prediction
  always @(posedge clk) begin
    int     hold_seen;
    int     hold_left;
    pixel_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen = hold_token;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("pixel write with none predicted");
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_address", 32'(out_ch.pixel_address), 32'(want.address));
          check_field("palette_index", 32'(out_ch.palette_index), 32'(want.pal_index));
          check_field("pixel_transparent", 32'(out_ch.pixel_transparent),
                      32'(want.transparent));
          check_field("image_has_transparency", 32'(out_ch.image_has_transparency),
                      32'(want.has_transparency));
          check_field("last_of_burst", 32'(out_ch.last_of_burst), 32'(want.last_in_burst));
          check_field("image_done", 32'(out_ch.image_done), 32'(want.done));
        end
        pixels_seen++;
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_mode == IDLE_SNK) begin
        out_ch.ready <= ($urandom_range(99) >= 74);
      end else if (idle_mode == IDLE_BOTH) begin
        out_ch.ready <= ($urandom_range(99) >= 14);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("TIMEOUT @%0t: %0d pixels still predicted", $time, pixel_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_beat(logic [7:0] d, bit rs, bit is);
    byte_beat_t b;
    b.data_byte   = d;
    b.row_start   = rs;
    b.image_start = is;
    byte_q.push_back(b);
    beats_queued++;
  endtask

  // everything taken, predicted and drained; then let a dropped byte finish
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_q.size() != 0 || in_ch.valid || pixel_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [prd_pkg::CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[prd_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      prd_pkg::CFG_COMPRESSED_MODE: mode_r   = value[0];
      prd_pkg::CFG_IMAGE_WIDTH:     width_r  = value[6:0];
      prd_pkg::CFG_IMAGE_HEIGHT:    height_r = value[6:0];
      prd_pkg::CFG_BUFFER_WIDTH:    pitch_r  = value[6:0];
      prd_pkg::CFG_X_OFFSET:        xoff_r   = value[5:0];
      prd_pkg::CFG_Y_OFFSET:        yoff_r   = value[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int mode, int w, int h, int pitch, int xo, int yo);
    write_reg(prd_pkg::CFG_COMPRESSED_MODE, mode);
    write_reg(prd_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(prd_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(prd_pkg::CFG_BUFFER_WIDTH, pitch);
    write_reg(prd_pkg::CFG_X_OFFSET, xo);
    write_reg(prd_pkg::CFG_Y_OFFSET, yo);
  endtask

  // one row of well-formed data, sometimes cut short
  task automatic gen_row(bit first);
    int         col, len, w;
    bit         head;
    logic [7:0] d;
    w    = int'(clamp_side(width_r));
    col  = 0;
    head = 1'b1;
    if (w == 0) begin
      push_beat(8'($urandom_range(255)), 1'b1, first);
      return;
    end
    while (col < w) begin
      if (!head && $urandom_range(99) < 5) break;
      if (mode_r && $urandom_range(99) < 35) begin
        len = $urandom_range(31);
        push_beat({prd_pkg::RUN_MARK, 5'(len)}, head, head && first);
        d = ($urandom_range(99) < 20) ? 8'(254 + $urandom_range(1)) : 8'($urandom_range(255));
        push_beat(d, 1'b0, 1'b0);
        col += (len > w - col) ? w - col : len;
      end else begin
        d = mode_r ? 8'($urandom_range(8'hDF)) : 8'($urandom_range(255));
        push_beat(d, head, head && first);
        col++;
      end
      head = 1'b0;
    end
    // stray byte past the row end
    if ($urandom_range(99) < 8) push_beat(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic gen_image();
    int rows;
    rows = int'(clamp_side(height_r));
    if (rows > 8 && $urandom_range(3) != 0) rows = $urandom_range(1, 8);
    if (rows == 0 || $urandom_range(9) == 0) rows++;
    for (int r = 0; r < rows; r++) gen_row(r == 0);
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      push_beat(8'($urandom_range(255)), $urandom_range(9) == 0, $urandom_range(19) == 0);
  endtask

  task automatic gen_stream(int count);
    int start;
    start = beats_queued;
    while (beats_queued - start < count) begin
      if ($urandom_range(99) < 80) gen_image();
      else gen_noise();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    idle_mode         = IDLE_NONE;
    hold_token        = 0;
    beats_queued      = 0;
    mismatch_count    = 0;
    pixels_seen       = 0;
    mode_r   = 1'b1;
    width_r  = prd_pkg::SIDE_RESET;
    height_r = prd_pkg::SIDE_RESET;
    pitch_r  = prd_pkg::SIDE_RESET;
    xoff_r   = '0;
    yoff_r   = '0;
    cur_col    = '0;
    rows_to_go = '0;
    run_armed  = 1'b0;
    run_len    = '0;
    row_closed = 1'b1;
    saw_clear  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, literals, full run, zero run, run cut by row start
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'hDF, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'hFE, 1'b0, 1'b0);
    push_beat(8'hE0, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'hE3, 1'b0, 1'b0);
    push_beat(8'h12, 1'b1, 1'b0);
    push_beat(8'h80, 1'b0, 1'b0);
    push_beat(8'h7F, 1'b0, 1'b0);
    push_beat(8'h01, 1'b0, 1'b0);
    push_beat(8'hE5, 1'b0, 1'b0);
    wait_idle();
    // mode drops to raw with a run pending: next byte is still its index
    write_reg(prd_pkg::CFG_COMPRESSED_MODE, 0);
    push_beat(8'hFD, 1'b0, 1'b0);
    push_beat(8'hE2, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    wait_idle();
    // width shrinks below the current column
    write_reg(prd_pkg::CFG_IMAGE_WIDTH, 4);
    push_beat(8'h33, 1'b0, 1'b0);
    push_beat(8'h34, 1'b0, 1'b0);
    push_beat(8'h35, 1'b1, 1'b0);
    wait_idle();
    write_reg(prd_pkg::CFG_IMAGE_HEIGHT, 0);
    push_beat(8'h10, 1'b0, 1'b1);
    push_beat(8'h11, 1'b1, 1'b0);
    wait_idle();
    write_reg(prd_pkg::CFG_IMAGE_HEIGHT, 2);
    write_reg(prd_pkg::CFG_IMAGE_WIDTH, 0);
    push_beat(8'h21, 1'b0, 1'b1);
    wait_idle();
    // largest values: address wraps
    write_reg(prd_pkg::CFG_IMAGE_WIDTH, 127);
    write_reg(prd_pkg::CFG_BUFFER_WIDTH, 127);
    write_reg(prd_pkg::CFG_X_OFFSET, 63);
    write_reg(prd_pkg::CFG_Y_OFFSET, 63);
    write_reg(CFG_SPARE_INDEX, 127);
    push_beat(8'h44, 1'b0, 1'b1);
    push_beat(8'hFE, 1'b0, 1'b0);
    push_beat(8'h01, 1'b1, 1'b0);
    push_beat(8'hC3, 1'b0, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(1, 8, 3, 16, 4, 2);
        1: set_config(1, $urandom_range(1, 16), $urandom_range(1, 4), $urandom_range(1, 127),
                      $urandom_range(63), $urandom_range(63));
        2: set_config(0, 5, 2, 9, 32, 32);
        3: set_config(1, 1, 64, 1, 0, 0);
        4: set_config(1, 64, 1, 64, 63, 63);
        5: set_config(0, 127, 2, 127, 0, 32);
        6: set_config(1, $urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(1, 127),
                      $urandom_range(63), $urandom_range(63));
        default: set_config(1, $urandom_range(1, 20), $urandom_range(1, 3), 64,
                            $urandom_range(32), $urandom_range(32));
      endcase
      case (ph % 4)
        0: idle_mode <= IDLE_NONE;
        1: idle_mode <= IDLE_SRC;
        2: idle_mode <= IDLE_SNK;
        default: idle_mode <= IDLE_BOTH;
      endcase
      // receiver blocks while the queue is full of beats
      if (ph == 2) hold_token <= hold_token + 1;
      if (ph == NUM_PHASES - 1) begin
        gen_stream(PHASE_BEATS / 2);
        wait_idle();
        gen_stream(PHASE_BEATS / 2);
      end else begin
        gen_stream(PHASE_BEATS);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/prd_pkg.sv
hw/rtl/prd_in_if.sv
hw/rtl/prd_out_if.sv
hw/rtl/prd_ctrl.sv
hw/rtl/prd_datapath.sv
hw/rtl/palette_rle_row_decoder_unit.sv
tb/tb_palette_rle_row_decoder_unit.sv
